// ----- rtl/kteq_pkg.sv -----
// kteq_pkg: beat types, command and status codes for the keyed tone event queue.
// No dependencies; imported by keyed_tone_event_queue.
package kteq_pkg;

   localparam int CHAN_W   = 5;
   localparam int TONE_W   = 8;
   localparam int STATUS_W = 2;

   localparam logic CMD_ENQ = 1'b0;
   localparam logic CMD_DEQ = 1'b1;

   localparam logic [STATUS_W-1:0] ST_DONE      = 2'd0;
   localparam logic [STATUS_W-1:0] ST_FULL      = 2'd1;
   localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd2;

   typedef struct packed {
      logic              cmd;
      logic [CHAN_W-1:0] channel;
      logic [TONE_W-1:0] tone_code;
   } req_type;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [TONE_W-1:0]   tone_out;
   } rsp_type;

endpackage

// ----- rtl/keyed_tone_event_queue.sv -----
// keyed_tone_event_queue: ordered tone event queue with keyed removal by channel.
// Depends on kteq_pkg (beat types, command and status codes).
//
//   channel | dir | handshake            | beat
//   --------+-----+----------------------+--------------------------------
//   req     | in  | req_valid/req_ready  | kteq_pkg::req_type (cmd, channel, tone)
//   rsp     | out | rsp_valid/rsp_ready  | kteq_pkg::rsp_type (status, tone_out)
//
// One req beat per clock sustained while rsp is not stalled; a rsp beat passes
// from the input register, which loads when its req beat is taken, to the
// result register, which presents it on rsp.
// The queue update and the result are computed combinationally from the input
// register: a parallel compare over all QUEUE_DEPTH slots, a priority pick of
// the oldest match and a one-step shift that closes the gap.
// Reset (synchronous, active high) empties the queue and both stage valids.
// A stalled rsp holds the result register; the input register then holds too,
// and req_ready drops only once both are occupied.
module keyed_tone_event_queue #(
   parameter int QUEUE_DEPTH = 16
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  kteq_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output kteq_pkg::rsp_type rsp_data
);
   import kteq_pkg::*;

   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   // input stage
   logic    in_valid_ff, in_valid_in;
   req_type in_beat_ff;

   // queue storage; slots below cnt_ff hold entries, oldest in slot 0
   logic [CHAN_W-1:0] chan_ff [QUEUE_DEPTH];
   logic [TONE_W-1:0] tone_ff [QUEUE_DEPTH];
   logic [CNT_W-1:0]  cnt_ff, cnt_in;

   // result stage
   logic    out_valid_ff, out_valid_in;
   rsp_type out_beat_ff, out_beat_in;

   logic                   advance;
   logic                   full;
   logic [QUEUE_DEPTH-1:0] match;
   logic [QUEUE_DEPTH-1:0] first;   // one-hot oldest match
   logic [QUEUE_DEPTH-1:0] shift;   // slots at or behind the removed one
   logic [TONE_W-1:0]      hit_tone;
   logic                   hit;
   logic                   do_enq;
   logic                   do_deq;

   assign advance   = in_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;
   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_beat_ff;

   assign full = (cnt_ff == CNT_W'(QUEUE_DEPTH));

   always_comb begin
      for (int i = 0; i < QUEUE_DEPTH; i++) begin
         match[i] = (CNT_W'(i) < cnt_ff) && (chan_ff[i] == in_beat_ff.channel);
      end
   end

   // lowest set bit, and everything from it upward
   assign first = match & (~match + QUEUE_DEPTH'(1));
   assign shift = ~(first - QUEUE_DEPTH'(1));
   assign hit   = |match;

   always_comb begin
      hit_tone = '0;
      for (int i = 0; i < QUEUE_DEPTH; i++) begin
         hit_tone = hit_tone | (first[i] ? tone_ff[i] : '0);
      end
   end

   assign do_enq = advance && (in_beat_ff.cmd == CMD_ENQ) && !full;
   assign do_deq = advance && (in_beat_ff.cmd == CMD_DEQ) && hit;

   always_comb begin
      cnt_in = cnt_ff;
      if (do_enq) begin
         cnt_in = cnt_ff + CNT_W'(1);
      end else if (do_deq) begin
         cnt_in = cnt_ff - CNT_W'(1);
      end
   end

   always_comb begin
      out_beat_in = '0;
      if (in_beat_ff.cmd == CMD_ENQ) begin
         out_beat_in.status = full ? ST_FULL : ST_DONE;
      end else if (hit) begin
         out_beat_in.status   = ST_DONE;
         out_beat_in.tone_out = hit_tone;
      end else begin
         out_beat_in.status = ST_NOT_FOUND;
      end
   end

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_valid && req_ready) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
      out_valid_in = out_valid_ff;
      if (advance) begin
         out_valid_in = 1'b1;
      end else if (rsp_ready) begin
         out_valid_in = 1'b0;
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         cnt_ff       <= '0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         cnt_ff       <= cnt_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_beat_ff <= req_data;
      end
      if (advance) begin
         out_beat_ff <= out_beat_in;
      end
   end

   // queue slots: append at the tail, or pull later slots down one place
   always_ff @(posedge clock) begin
      for (int i = 0; i < QUEUE_DEPTH; i++) begin
         if (do_enq && (cnt_ff == CNT_W'(i))) begin
            chan_ff[i] <= in_beat_ff.channel;
            tone_ff[i] <= in_beat_ff.tone_code;
         end else if (do_deq && shift[i] && (i < QUEUE_DEPTH - 1)) begin
            chan_ff[i] <= chan_ff[(i + 1) % QUEUE_DEPTH];
            tone_ff[i] <= tone_ff[(i + 1) % QUEUE_DEPTH];
         end
      end
   end

`ifndef SYNTH
   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CNT_W'(QUEUE_DEPTH))
      else $error("entry count above queue depth");

   a_enq_grows: assert property (@(posedge clock) disable iff (reset)
      do_enq |=> cnt_ff == $past(cnt_ff) + CNT_W'(1))
      else $error("enqueue did not add an entry");

   a_deq_shrinks: assert property (@(posedge clock) disable iff (reset)
      do_deq |=> cnt_ff == $past(cnt_ff) - CNT_W'(1))
      else $error("dequeue hit did not remove an entry");

   a_fail_no_tone: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_data.status != ST_DONE)) |-> (rsp_data.tone_out == '0))
      else $error("failed operation returned a tone");
`endif

endmodule
